FILE: rtl/bds_pkg.sv
package bds_pkg;

  localparam int Q_BITS = 32;
  localparam int GAP_W = 26;
  localparam int MUL_A_W = Q_BITS + 1;
  localparam int MUL_B_W = GAP_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PEN_W = 17;

  localparam logic [2:0] REG_MODE_FLAGS = 3'd0;
  localparam logic [2:0] REG_BURST_MIN = 3'd1;
  localparam logic [2:0] REG_BURST_MAX = 3'd2;
  localparam logic [2:0] REG_UPLOAD_LIMIT = 3'd3;
  localparam logic [2:0] REG_GAP_MIN = 3'd4;
  localparam logic [2:0] REG_GAP_MAX = 3'd5;
  localparam logic [2:0] REG_IDLE_MIN = 3'd6;
  localparam logic [2:0] REG_IDLE_MAX = 3'd7;

  localparam logic [MUL_B_W-1:0] PENALTY_SCALE = MUL_B_W'(50000);
  localparam logic [PEN_W-1:0] PENALTY_CAP = PEN_W'(100000);

  typedef struct packed {
    logic [3:0] mode_flags;
    logic [7:0] min_burst_len;
    logic [7:0] max_burst_len;
    logic [15:0] upload_limit_q16;
    logic [GAP_W-1:0] gap_min_us;
    logic [GAP_W-1:0] gap_max_us;
    logic [GAP_W-1:0] idle_min_us;
    logic [GAP_W-1:0] idle_max_us;
  } cfg_regs_t;

endpackage

FILE: rtl/bds_ifs.sv
interface bds_pkt_if;
  logic valid;
  logic ready;
  logic [15:0] packet_bytes;
  logic upload;
  logic [15:0] rand_length;
  logic [15:0] rand_gap;
  logic [15:0] rand_noise;
  modport source(output valid, packet_bytes, upload, rand_length, rand_gap, rand_noise,
                 input ready);
  modport sink(input valid, packet_bytes, upload, rand_length, rand_gap, rand_noise,
               output ready);
endinterface

interface bds_res_if;
  logic valid;
  logic ready;
  logic [31:0] delay_us;
  logic ratio_penalized;
  logic burst_started;
  logic in_burst;
  modport source(output valid, delay_us, ratio_penalized, burst_started, in_burst,
                 input ready);
  modport sink(input valid, delay_us, ratio_penalized, burst_started, in_burst,
               output ready);
endinterface

interface bds_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] reg_index;
  logic [25:0] wr_data;
  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

FILE: rtl/bds_div.sv
module bds_div
  import bds_pkg::*;
#(
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [Q_BITS-1:0] quo,
  output logic          done
);

  localparam int CNT_W = $clog2(Q_BITS + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW:0] shifted;
  logic [DW:0] diff;
  logic take;

  assign shifted = {rem, 1'b0};
  assign diff = shifted - {1'b0, den};
  assign take = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(Q_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      quo <= '0;
    end else if (cnt != '0) begin
      rem <= take ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[Q_BITS-2:0], take};
    end
  end

endmodule

FILE: rtl/burst_traffic_delay_shaper.sv
// Channel  Dir  Beat contents
// pkt      in   packet_bytes, upload, rand_length, rand_gap, rand_noise
// res      out  delay_us, ratio_penalized, burst_started, in_burst
// cfg      in   reg_index, wr_data
//
// A packet beat is taken only while the sequencer is idle. Steps: ratio, the 32-step serial
// divider if an upload needs it, penalty, length, gap, noise, final; final alone if disabled.
// All products go through one registered multiplier, one per sequencer step.
// The result register lets the next packet enter while a result waits; the sequencer
// holds in its last step only if the previous result is still not taken.
// Reset is synchronous and restores the register defaults and clears all totals.
module burst_traffic_delay_shaper
  import bds_pkg::*;
#(
  parameter int TOTAL_BITS = 48
) (
  input  logic clk,
  input  logic rst,
  bds_pkt_if.sink pkt,
  bds_res_if.source res,
  bds_cfg_if.sink cfg
);

  localparam int DW = TOTAL_BITS + 1;
  localparam bit WIDE = (TOTAL_BITS >= 64);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RATIO = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_PEN = 3'd3;
  localparam logic [2:0] S_LEN = 3'd4;
  localparam logic [2:0] S_GAP = 3'd5;
  localparam logic [2:0] S_NOISE = 3'd6;
  localparam logic [2:0] S_FIN = 3'd7;

  cfg_regs_t regs;
  logic [2:0] state;
  logic [15:0] r_len;
  logic [15:0] r_gap;
  logic [15:0] r_noise;
  logic up_flag;
  logic [TOTAL_BITS-1:0] up_total;
  logic [TOTAL_BITS-1:0] down_total;
  logic bursting;
  logic [7:0] burst_count;
  logic [7:0] burst_target;
  logic ratio_act;
  logic [MUL_A_W-1:0] q_frac;
  logic pen_on;
  logic [PEN_W-1:0] penalty;
  logic started;
  logic base_en;
  logic draw_dir;
  logic [GAP_W-1:0] draw_lo;
  logic [GAP_W-1:0] base;
  logic [MUL_P_W-1:0] mul_prod;
  logic out_valid;
  logic [31:0] out_delay;
  logic out_pen;
  logic out_started;
  logic out_burst;

  logic pkt_acc;
  logic [TOTAL_BITS-1:0] add_in;
  logic [DW-1:0] add_sum;
  logic [TOTAL_BITS-1:0] add_sat;
  logic [DW-1:0] sum_raw;
  logic [DW-1:0] sum_half;
  logic ovf;
  logic [DW-1:0] u_eff;
  logic [DW-1:0] tot_eff;
  logic ratio_go;
  logic div_start;
  logic [Q_BITS-1:0] div_quo;
  logic div_done;
  logic [MUL_A_W-1:0] lim33;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [26:0] pen_raw;
  logic [7:0] hi;
  logic [8:0] span;
  logic [7:0] target_new;
  logic new_burst;
  logic [GAP_W-1:0] draw_a;
  logic [GAP_W-1:0] draw_b;
  logic draw_up;
  logic [GAP_W-1:0] draw_diff;
  logic [GAP_W-1:0] draw_off;
  logic [24:0] noise;
  logic [31:0] delay_sum;
  logic fin_go;

  assign pkt.ready = (state == S_IDLE);
  assign pkt_acc = pkt.valid && pkt.ready;
  assign cfg.ready = 1'b1;

  assign add_in = pkt.upload ? up_total : down_total;
  assign add_sum = {1'b0, add_in} + DW'(pkt.packet_bytes);
  assign add_sat = add_sum[TOTAL_BITS] ? '1 : add_sum[TOTAL_BITS-1:0];

  assign sum_raw = {1'b0, up_total} + {1'b0, down_total};
  assign sum_half = DW'(up_total >> 1) + DW'(down_total >> 1);
  assign ovf = WIDE && sum_raw[TOTAL_BITS];
  assign u_eff = ovf ? DW'(up_total >> 1) : {1'b0, up_total};
  assign tot_eff = ovf ? sum_half : sum_raw;
  assign ratio_go = regs.mode_flags[1] && up_flag && (tot_eff != '0);
  assign div_start = (state == S_RATIO) && ratio_go && (u_eff < tot_eff);

  bds_div #(.DW(DW)) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(u_eff),
    .den(tot_eff),
    .quo(div_quo),
    .done(div_done)
  );

  assign lim33 = {1'b0, regs.upload_limit_q16, 16'b0};
  assign pen_raw = mul_prod[MUL_P_W-1:Q_BITS];
  assign hi = (regs.max_burst_len < regs.min_burst_len) ? regs.min_burst_len
                                                         : regs.max_burst_len;
  assign span = {1'b0, hi} - {1'b0, regs.min_burst_len} + 9'd1;
  assign target_new = regs.min_burst_len + mul_prod[23:16];
  assign new_burst = !bursting || (burst_count < burst_target);
  assign draw_a = new_burst ? regs.gap_min_us : regs.idle_min_us;
  assign draw_b = new_burst ? regs.gap_max_us : regs.idle_max_us;
  assign draw_up = draw_b >= draw_a;
  assign draw_diff = draw_up ? draw_b - draw_a : draw_a - draw_b;
  assign draw_off = mul_prod[41:16];
  assign noise = (regs.mode_flags[0] && regs.mode_flags[3]) ? mul_prod[41:17] : '0;
  assign delay_sum = 32'(base) + 32'(noise) + 32'(penalty);
  assign fin_go = (state == S_FIN) && (!out_valid || res.ready);

  always_comb begin
    case (state)
      S_PEN: begin
        mul_a = q_frac - lim33;
        mul_b = PENALTY_SCALE;
      end
      S_LEN: begin
        mul_a = MUL_A_W'(r_len);
        mul_b = MUL_B_W'(span);
      end
      S_GAP: begin
        mul_a = MUL_A_W'(r_gap);
        mul_b = draw_diff;
      end
      default: begin
        mul_a = MUL_A_W'(r_noise);
        mul_b = regs.gap_max_us;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode_flags <= 4'd0;
      regs.min_burst_len <= 8'd5;
      regs.max_burst_len <= 8'd30;
      regs.upload_limit_q16 <= 16'd13107;
      regs.gap_min_us <= GAP_W'(50000);
      regs.gap_max_us <= GAP_W'(200000);
      regs.idle_min_us <= GAP_W'(2000000);
      regs.idle_max_us <= GAP_W'(8000000);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_MODE_FLAGS: regs.mode_flags <= cfg.wr_data[3:0];
        REG_BURST_MIN: regs.min_burst_len <= cfg.wr_data[7:0];
        REG_BURST_MAX: regs.max_burst_len <= cfg.wr_data[7:0];
        REG_UPLOAD_LIMIT: regs.upload_limit_q16 <= cfg.wr_data[15:0];
        REG_GAP_MIN: regs.gap_min_us <= cfg.wr_data;
        REG_GAP_MAX: regs.gap_max_us <= cfg.wr_data;
        REG_IDLE_MIN: regs.idle_min_us <= cfg.wr_data;
        REG_IDLE_MAX: regs.idle_max_us <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      up_total <= '0;
      down_total <= '0;
      bursting <= 1'b0;
      burst_count <= '0;
      burst_target <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pkt_acc) begin
            r_len <= pkt.rand_length;
            r_gap <= pkt.rand_gap;
            r_noise <= pkt.rand_noise;
            up_flag <= pkt.upload;
            started <= 1'b0;
            pen_on <= 1'b0;
            penalty <= '0;
            base <= '0;
            if (regs.mode_flags[0]) begin
              if (pkt.upload) begin
                up_total <= add_sat;
              end else begin
                down_total <= add_sat;
              end
              state <= S_RATIO;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RATIO: begin
          ratio_act <= ratio_go;
          q_frac <= MUL_A_W'(1) << Q_BITS;
          state <= div_start ? S_DIV : S_PEN;
        end
        S_DIV: begin
          if (div_done) begin
            q_frac <= {1'b0, div_quo};
            state <= S_PEN;
          end
        end
        S_PEN: begin
          pen_on <= ratio_act && (q_frac > lim33);
          state <= S_LEN;
        end
        S_LEN: begin
          if (pen_on) begin
            penalty <= (pen_raw > 27'(PENALTY_CAP)) ? PENALTY_CAP : pen_raw[PEN_W-1:0];
          end
          state <= S_GAP;
        end
        S_GAP: begin
          if (!bursting) begin
            burst_target <= target_new;
            burst_count <= 8'd1;
            bursting <= 1'b1;
            started <= 1'b1;
          end else if (burst_count < burst_target) begin
            if (burst_count != 8'hFF) begin
              burst_count <= burst_count + 8'd1;
            end
          end else begin
            bursting <= 1'b0;
          end
          base_en <= new_burst || regs.mode_flags[2];
          draw_dir <= draw_up;
          draw_lo <= draw_a;
          state <= S_NOISE;
        end
        S_NOISE: begin
          if (base_en) begin
            base <= draw_dir ? draw_lo + draw_off : draw_lo - draw_off;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_delay <= delay_sum;
            out_pen <= pen_on;
            out_started <= started;
            out_burst <= bursting;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = out_valid;
  assign res.delay_us = out_delay;
  assign res.ratio_penalized = out_pen;
  assign res.burst_started = out_started;
  assign res.in_burst = out_burst;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait step");

  a_fin_loads_result: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> res.valid && state == S_IDLE)
    else $error("final step did not present a result");

  a_start_means_burst: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.burst_started |-> res.in_burst)
    else $error("burst start reported while idle");

  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.delay_us[31:28] == 4'd0)
    else $error("delay exceeds the reachable range");
`endif

endmodule
